// File: design/swm_pkg.sv
// Shared constants and payload types for the sliding window maximum unit.
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int WS_W        = 7;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int CELLS       = (WINDOW_MAX > 1) ? WINDOW_MAX - 1 : 1;
    localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_sample window_max;
        logic    final_result;
    } t_out_item;

    // Step signals that the top level hands to every cell of the chain.
    typedef struct packed {
        logic    shift;
        t_sample sample;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: design/swm_cell.sv
// One cell of the running-maximum chain: max of the new sample and the neighbor's value.
`default_nettype none

module swm_cell (
    input  wire logic                i_clk,
    input  wire swm_pkg::t_cell_ctl  i_ctl,
    input  wire swm_pkg::t_sample    i_prev,
    output swm_pkg::t_sample         o_max
);

    swm_pkg::t_sample r_max;
    swm_pkg::t_sample n_max;

    // Cell k holds the max of the latest k+1 samples.
    always_comb begin
        n_max = (i_ctl.sample > i_prev) ? i_ctl.sample : i_prev;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_max <= n_max;
        end
    end

    assign o_max = r_max;

endmodule

`default_nettype wire

// File: design/sliding_window_max_unit.sv
// Top level of the sliding window maximum unit: fill control, cell chain, output register.
//
// Input requests arrive on i_in_valid / o_in_stall with a t_in_item payload (sample and
// end_of_stream); a request is taken on a clock edge with valid high and stall low.
// Results leave on o_out_valid / i_out_stall with a t_out_item payload.
// One request is taken every cycle unless stalled; its result comes in the next cycle, from
// a single output register. The rate is set by the cell chain: each cell keeps the max
// of the latest k+1 samples and updates from its neighbor with one compare per cycle.
// A result is given once the current stream holds at least window_size samples;
// a request flagged end_of_stream closes the stream and the fill count clears.
// window_size is written via i_cfg_we / i_cfg_data; the user must do so only while the
// unit is idle; the block does not enforce it. 0 acts as 1, values above 64 act as 64.
// While the receiver stalls a waiting result, o_in_stall is raised and the result
// holds; an empty or draining output register lets requests through.
// Reset (i_rst_n low, synchronous) clears the fill count, drops any waiting result and
// loads window_size with 3. Cell contents are not cleared; they are read only after
// the current stream has written them.
`default_nettype none

module sliding_window_max_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire swm_pkg::t_in_item            i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output swm_pkg::t_out_item                o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [swm_pkg::WS_W-1:0]     i_cfg_data
);

    logic [swm_pkg::WS_W-1:0]  r_ws;
    logic [swm_pkg::CNT_W-1:0] r_fill;
    logic [swm_pkg::CNT_W-1:0] n_fill;
    logic                      r_out_valid;
    swm_pkg::t_out_item        r_out;

    logic                      accept;
    logic                      produce;
    logic [swm_pkg::CNT_W-1:0] w_eff;
    logic [swm_pkg::CNT_W-1:0] fill_inc;
    swm_pkg::t_sample          sel_max;
    swm_pkg::t_sample          best;
    swm_pkg::t_cell_ctl        cell_ctl;
    swm_pkg::t_sample          cell_q [swm_pkg::CELLS];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        cell_ctl.shift  = accept;
        cell_ctl.sample = i_in_data.sample;
    end

    for (genvar k = 0; k < swm_pkg::CELLS; k++) begin : g_cell
        swm_pkg::t_sample prev;
        if (k == 0) begin : g_head
            assign prev = i_in_data.sample;
        end else begin : g_link
            assign prev = cell_q[k-1];
        end
        swm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_prev (prev),
            .o_max  (cell_q[k])
        );
    end

    // Clamp the configured window into 1..WINDOW_MAX.
    always_comb begin
        if (r_ws == '0) begin
            w_eff = swm_pkg::CNT_W'(1);
        end else if (int'(r_ws) > swm_pkg::WINDOW_MAX) begin
            w_eff = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
        end else begin
            w_eff = swm_pkg::CNT_W'(r_ws);
        end
    end

    assign fill_inc = (r_fill < swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX)) ?
                      r_fill + 1'b1 : r_fill;
    assign produce  = fill_inc >= w_eff;
    assign n_fill   = i_in_data.end_of_stream ? '0 : fill_inc;

    // Window w takes cell w-2 (max of the w-1 older samples) against the new sample.
    always_comb begin
        sel_max = '0;
        for (int k = 0; k < swm_pkg::WINDOW_MAX - 1; k++) begin
            if (w_eff == swm_pkg::CNT_W'(k + 2)) begin
                sel_max = sel_max | cell_q[k];
            end
        end
        if (w_eff == swm_pkg::CNT_W'(1)) begin
            best = i_in_data.sample;
        end else begin
            best = (sel_max > i_in_data.sample) ? sel_max : i_in_data.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= swm_pkg::WS_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws <= i_cfg_data;
            end
            if (accept) begin
                r_fill      <= n_fill;
                r_out_valid <= produce;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.window_max   <= best;
            r_out.final_result <= i_in_data.end_of_stream;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= swm_pkg::WINDOW_MAX)
        else $error("fill count beyond window depth");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.end_of_stream |=> r_fill == '0)
        else $error("fill count not cleared after end of stream");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && produce |=> o_out_valid)
        else $error("expected result missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !produce |=> !o_out_valid)
        else $error("result given before window filled");

endmodule

`default_nettype wire
